// ===== rtl/qapm_pkg.sv =====
// qapm_pkg: shared types and constants for the quad attitude PID mixer.
// Used by every module of the block. No dependencies.
`default_nettype none

package qapm_pkg;

   localparam int GAIN_WIDTH      = 16;
   localparam int LIMIT_WIDTH     = 10;
   localparam int THROTTLE_WIDTH  = 12;
   localparam int DRIVE_WIDTH     = 11;
   localparam int MOTOR_WIDTH     = 14;
   localparam int PROD_FRAC       = 12;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_RP_P_GAIN  = 3'd0,
      CSR_RP_I_GAIN  = 3'd1,
      CSR_RP_D_GAIN  = 3'd2,
      CSR_RP_LIMIT   = 3'd3,
      CSR_YAW_P_GAIN = 3'd4,
      CSR_YAW_I_GAIN = 3'd5,
      CSR_YAW_D_GAIN = 3'd6,
      CSR_YAW_LIMIT  = 3'd7
   } csr_index_type;

   localparam logic [GAIN_WIDTH-1:0]  RP_P_GAIN_RESET  = 16'd77;
   localparam logic [GAIN_WIDTH-1:0]  RP_I_GAIN_RESET  = 16'd51;
   localparam logic [GAIN_WIDTH-1:0]  RP_D_GAIN_RESET  = 16'd2560;
   localparam logic [LIMIT_WIDTH-1:0] RP_LIMIT_RESET   = 10'd350;
   localparam logic [GAIN_WIDTH-1:0]  YAW_P_GAIN_RESET = 16'd51;
   localparam logic [GAIN_WIDTH-1:0]  YAW_I_GAIN_RESET = 16'd0;
   localparam logic [GAIN_WIDTH-1:0]  YAW_D_GAIN_RESET = 16'd2560;
   localparam logic [LIMIT_WIDTH-1:0] YAW_LIMIT_RESET  = 10'd350;

   typedef struct packed {
      logic [GAIN_WIDTH-1:0]  p_gain;
      logic [GAIN_WIDTH-1:0]  i_gain;
      logic [GAIN_WIDTH-1:0]  d_gain;
      logic [LIMIT_WIDTH-1:0] limit;
   } axis_gains_type;

   // stage load strobes shared by all axis datapaths
   typedef struct packed {
      logic s1_load;
      logic s2_load;
      logic s3_load;
   } pipe_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/qapm_csr.sv =====
// qapm_csr: gain and limit registers, written through the csr write port.
// Depends on qapm_pkg.
`default_nettype none

module qapm_csr
   import qapm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   output axis_gains_type             rp_gains,
   output axis_gains_type             yaw_gains
);

   axis_gains_type rp_ff, rp_in;
   axis_gains_type yaw_ff, yaw_in;

   always_comb begin
      rp_in  = rp_ff;
      yaw_in = yaw_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_RP_P_GAIN:  rp_in.p_gain  = csr_data[GAIN_WIDTH-1:0];
            CSR_RP_I_GAIN:  rp_in.i_gain  = csr_data[GAIN_WIDTH-1:0];
            CSR_RP_D_GAIN:  rp_in.d_gain  = csr_data[GAIN_WIDTH-1:0];
            CSR_RP_LIMIT:   rp_in.limit   = csr_data[LIMIT_WIDTH-1:0];
            CSR_YAW_P_GAIN: yaw_in.p_gain = csr_data[GAIN_WIDTH-1:0];
            CSR_YAW_I_GAIN: yaw_in.i_gain = csr_data[GAIN_WIDTH-1:0];
            CSR_YAW_D_GAIN: yaw_in.d_gain = csr_data[GAIN_WIDTH-1:0];
            CSR_YAW_LIMIT:  yaw_in.limit  = csr_data[LIMIT_WIDTH-1:0];
            default: begin
               rp_in  = rp_ff;
               yaw_in = yaw_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff  <= '{RP_P_GAIN_RESET, RP_I_GAIN_RESET, RP_D_GAIN_RESET, RP_LIMIT_RESET};
         yaw_ff <= '{YAW_P_GAIN_RESET, YAW_I_GAIN_RESET, YAW_D_GAIN_RESET,
                     YAW_LIMIT_RESET};
      end else begin
         rp_ff  <= rp_in;
         yaw_ff <= yaw_in;
      end
   end

   assign rp_gains  = rp_ff;
   assign yaw_gains = yaw_ff;

endmodule

`default_nettype wire

// ===== rtl/qapm_axis.sv =====
// qapm_axis: one PID axis. Error and delta register, product register,
// then integrator update and clamped drive. Depends on qapm_pkg.
`default_nettype none

module qapm_axis
   import qapm_pkg::*;
#(
   parameter int SW  = 16,
   parameter int IFB = 12
)(
   input  logic                          clock,
   input  logic                          reset,
   input  pipe_ctrl_type                 ctrl,
   input  logic signed [SW-1:0]          sample,
   input  axis_gains_type                gains,
   output logic signed [DRIVE_WIDTH-1:0] drive
);

   localparam int EW      = SW + 1;
   localparam int DW      = SW + 2;
   localparam int PPW     = GAIN_WIDTH + 1 + EW;
   localparam int DPW     = GAIN_WIDTH + 1 + DW;
   localparam int C_FRAC  = (IFB > PROD_FRAC) ? IFB : PROD_FRAC;
   localparam int IW      = LIMIT_WIDTH + IFB + 1;
   localparam int INC_SHL = (IFB >= PROD_FRAC) ? IFB - PROD_FRAC : 0;
   localparam int INC_SHR = (IFB < PROD_FRAC) ? PROD_FRAC - IFB : 0;
   localparam int INCW    = PPW + INC_SHL;
   localparam int IAW     = ((INCW > IW) ? INCW : IW) + 1;
   localparam int SH_P    = C_FRAC - PROD_FRAC;
   localparam int SH_I    = C_FRAC - IFB;
   localparam int SUMA    = DPW + SH_P + 2;
   localparam int SUMB    = IW + SH_I + 2;
   localparam int SUMW    = (SUMA > SUMB) ? SUMA : SUMB;
   localparam logic signed [SUMW-1:0] RND_BIAS = (SUMW'(1) << C_FRAC) - SUMW'(1);

   logic signed [EW-1:0]   prev_ff, prev_in;
   logic signed [EW-1:0]   err_ff;
   logic signed [DW-1:0]   diff_ff;
   logic signed [PPW-1:0]  pprod_ff, iprod_ff;
   logic signed [DPW-1:0]  dprod_ff;
   logic signed [IW-1:0]   integ_ff, integ_in;

   logic signed [EW-1:0]   err_c;
   logic signed [DW-1:0]   diff_c;
   logic signed [INCW-1:0] inc;
   logic signed [IAW-1:0]  isum, ilim;
   logic signed [SUMW-1:0] sum, slim, sum_clamp, sum_adj;

   // stage 1: error is the negated sample, one extra bit for the most negative
   assign err_c   = -EW'(sample);
   assign diff_c  = DW'(err_c) - DW'(prev_ff);
   assign prev_in = ctrl.s1_load ? err_c : prev_ff;

   always_ff @(posedge clock) begin
      if (ctrl.s1_load) begin
         err_ff  <= err_c;
         diff_ff <= diff_c;
      end
      if (ctrl.s2_load) begin
         pprod_ff <= $signed({1'b0, gains.p_gain}) * err_ff;
         iprod_ff <= $signed({1'b0, gains.i_gain}) * err_ff;
         dprod_ff <= $signed({1'b0, gains.d_gain}) * diff_ff;
      end
   end

   // stage 3: integrator update and drive
   assign inc  = (INCW'(iprod_ff) <<< INC_SHL) >>> INC_SHR;
   assign isum = IAW'(integ_ff) + IAW'(inc);
   assign ilim = IAW'({1'b0, gains.limit}) << IFB;

   always_comb begin
      if (isum > ilim) begin
         integ_in = IW'(ilim);
      end else if (isum < -ilim) begin
         integ_in = IW'(-ilim);
      end else begin
         integ_in = IW'(isum);
      end
   end

   assign sum = (SUMW'(pprod_ff) <<< SH_P) + (SUMW'(integ_in) <<< SH_I)
              + (SUMW'(dprod_ff) <<< SH_P);
   assign slim = SUMW'({1'b0, gains.limit}) << C_FRAC;

   always_comb begin
      if (sum > slim) begin
         sum_clamp = slim;
      end else if (sum < -slim) begin
         sum_clamp = -slim;
      end else begin
         sum_clamp = sum;
      end
   end

   // round toward zero
   assign sum_adj = sum_clamp + (sum_clamp[SUMW-1] ? RND_BIAS : '0);
   assign drive   = DRIVE_WIDTH'(sum_adj >>> C_FRAC);

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         integ_ff <= '0;
      end else begin
         prev_ff <= prev_in;
         if (ctrl.s3_load) begin
            integ_ff <= integ_in;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/qapm_mixer.sv =====
// qapm_mixer: X-frame motor mixer, throttle plus signed axis drives.
// Depends on qapm_pkg.
`default_nettype none

module qapm_mixer
   import qapm_pkg::*;
(
   input  logic [THROTTLE_WIDTH-1:0]     throttle,
   input  logic signed [DRIVE_WIDTH-1:0] roll,
   input  logic signed [DRIVE_WIDTH-1:0] pitch,
   input  logic signed [DRIVE_WIDTH-1:0] yaw,
   output logic signed [MOTOR_WIDTH-1:0] front_right,
   output logic signed [MOTOR_WIDTH-1:0] front_left,
   output logic signed [MOTOR_WIDTH-1:0] rear_left,
   output logic signed [MOTOR_WIDTH-1:0] rear_right
);

   localparam int XW = MOTOR_WIDTH + 1;

   logic signed [XW-1:0] t_x, r_x, p_x, y_x;

   assign t_x = $signed(XW'(throttle));
   assign r_x = XW'(roll);
   assign p_x = XW'(pitch);
   assign y_x = XW'(yaw);

   assign front_right = MOTOR_WIDTH'(t_x - p_x + r_x - y_x);
   assign front_left  = MOTOR_WIDTH'(t_x - p_x - r_x + y_x);
   assign rear_left   = MOTOR_WIDTH'(t_x + p_x - r_x - y_x);
   assign rear_right  = MOTOR_WIDTH'(t_x + p_x + r_x + y_x);

endmodule

`default_nettype wire

// ===== rtl/quad_attitude_pid_mixer.sv =====
// quad_attitude_pid_mixer: three-axis attitude PID with X-frame motor mixer.
// Depends on qapm_pkg, qapm_csr, qapm_axis and qapm_mixer.
//
// Usage:
//   req channel: one transaction per control tick carries roll, pitch, yaw
//   measurements (signed, 4 fraction bits) and the throttle level.
//   rsp channel: one transaction per tick with the three clamped integer
//   drives and the four motor pulses.
//   csr port: gains and limits, written while no tick is in flight.
// From req acceptance to rsp_valid a transaction passes the input/error register,
// product register (gain multipliers), then integrator update, drive clamp
// and mixer into the output register. One transaction per cycle is sustained
// while rsp_stall is low; the integrator feedback loop lies in the last stage.
// Reset clears the pipeline valids, integrators and previous errors and
// loads the default gains. When rsp_stall is high the result holds in the
// output register; the two earlier stages keep filling, and req_stall
// rises only when all three stages hold a transaction.
`default_nettype none

module quad_attitude_pid_mixer
   import qapm_pkg::*;
#(
   parameter int SAMPLE_WIDTH             = 16,
   parameter int INTEGRATOR_FRACTION_BITS = 12
)(
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_roll_angle,
   input  logic signed [SAMPLE_WIDTH-1:0] req_pitch_angle,
   input  logic signed [SAMPLE_WIDTH-1:0] req_yaw_measure,
   input  logic [THROTTLE_WIDTH-1:0]      req_throttle_level,

   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [DRIVE_WIDTH-1:0]  rsp_roll_drive,
   output logic signed [DRIVE_WIDTH-1:0]  rsp_pitch_drive,
   output logic signed [DRIVE_WIDTH-1:0]  rsp_yaw_drive,
   output logic signed [MOTOR_WIDTH-1:0]  rsp_motor_front_right,
   output logic signed [MOTOR_WIDTH-1:0]  rsp_motor_front_left,
   output logic signed [MOTOR_WIDTH-1:0]  rsp_motor_rear_left,
   output logic signed [MOTOR_WIDTH-1:0]  rsp_motor_rear_right,

   input  logic                           csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]      csr_data
);

   axis_gains_type rp_gains, yaw_gains;
   pipe_ctrl_type  ctrl;

   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic out_valid_ff, out_valid_in;
   logic s1_ready, s2_ready, out_ready;

   logic [THROTTLE_WIDTH-1:0] thr_s1_ff, thr_s2_ff;

   logic signed [DRIVE_WIDTH-1:0] roll_c, pitch_c, yaw_c;
   logic signed [MOTOR_WIDTH-1:0] fr_c, fl_c, rl_c, rr_c;

   logic signed [DRIVE_WIDTH-1:0] roll_ff, pitch_ff, yaw_ff;
   logic signed [MOTOR_WIDTH-1:0] fr_ff, fl_ff, rl_ff, rr_ff;

   qapm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rp_gains  (rp_gains),
      .yaw_gains (yaw_gains)
   );

   assign out_ready = !out_valid_ff || !rsp_stall;
   assign s2_ready  = !s2_valid_ff || out_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;

   assign ctrl.s1_load = req_valid && s1_ready;
   assign ctrl.s2_load = s1_valid_ff && s2_ready;
   assign ctrl.s3_load = s2_valid_ff && out_ready;

   assign s1_valid_in  = s1_ready  ? req_valid   : s1_valid_ff;
   assign s2_valid_in  = s2_ready  ? s1_valid_ff : s2_valid_ff;
   assign out_valid_in = out_ready ? s2_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   qapm_axis #(.SW(SAMPLE_WIDTH), .IFB(INTEGRATOR_FRACTION_BITS)) u_roll (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .sample (req_roll_angle),
      .gains  (rp_gains),
      .drive  (roll_c)
   );

   qapm_axis #(.SW(SAMPLE_WIDTH), .IFB(INTEGRATOR_FRACTION_BITS)) u_pitch (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .sample (req_pitch_angle),
      .gains  (rp_gains),
      .drive  (pitch_c)
   );

   qapm_axis #(.SW(SAMPLE_WIDTH), .IFB(INTEGRATOR_FRACTION_BITS)) u_yaw (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .sample (req_yaw_measure),
      .gains  (yaw_gains),
      .drive  (yaw_c)
   );

   qapm_mixer u_mixer (
      .throttle    (thr_s2_ff),
      .roll        (roll_c),
      .pitch       (pitch_c),
      .yaw         (yaw_c),
      .front_right (fr_c),
      .front_left  (fl_c),
      .rear_left   (rl_c),
      .rear_right  (rr_c)
   );

   always_ff @(posedge clock) begin
      if (ctrl.s1_load) begin
         thr_s1_ff <= req_throttle_level;
      end
      if (ctrl.s2_load) begin
         thr_s2_ff <= thr_s1_ff;
      end
      if (ctrl.s3_load) begin
         roll_ff  <= roll_c;
         pitch_ff <= pitch_c;
         yaw_ff   <= yaw_c;
         fr_ff    <= fr_c;
         fl_ff    <= fl_c;
         rl_ff    <= rl_c;
         rr_ff    <= rr_c;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_roll_drive        = roll_ff;
   assign rsp_pitch_drive       = pitch_ff;
   assign rsp_yaw_drive         = yaw_ff;
   assign rsp_motor_front_right = fr_ff;
   assign rsp_motor_front_left  = fl_ff;
   assign rsp_motor_rear_left   = rl_ff;
   assign rsp_motor_rear_right  = rr_ff;

endmodule

`default_nettype wire

// ===== rtl/qapm_checker.sv =====
// qapm_checker: port-level assertions for quad_attitude_pid_mixer, bound to it.
// Depends on qapm_pkg.
`default_nettype none

module qapm_checker
   import qapm_pkg::*;
(
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic signed [DRIVE_WIDTH-1:0] rsp_roll_drive,
   input wire logic signed [DRIVE_WIDTH-1:0] rsp_pitch_drive,
   input wire logic signed [DRIVE_WIDTH-1:0] rsp_yaw_drive,
   input wire logic signed [MOTOR_WIDTH-1:0] rsp_motor_front_right,
   input wire logic signed [MOTOR_WIDTH-1:0] rsp_motor_front_left,
   input wire logic signed [MOTOR_WIDTH-1:0] rsp_motor_rear_left,
   input wire logic signed [MOTOR_WIDTH-1:0] rsp_motor_rear_right
);

   logic signed [MOTOR_WIDTH-1:0] roll_x, pitch_x, yaw_x;
   logic signed [MOTOR_WIDTH-1:0] fr_fl, rr_rl, rr_fr;
   logic signed [MOTOR_WIDTH-1:0] exp_fr_fl, exp_rr_rl, exp_rr_fr;

   assign roll_x  = MOTOR_WIDTH'(rsp_roll_drive);
   assign pitch_x = MOTOR_WIDTH'(rsp_pitch_drive);
   assign yaw_x   = MOTOR_WIDTH'(rsp_yaw_drive);

   assign fr_fl = rsp_motor_front_right - rsp_motor_front_left;
   assign rr_rl = rsp_motor_rear_right - rsp_motor_rear_left;
   assign rr_fr = rsp_motor_rear_right - rsp_motor_front_right;

   assign exp_fr_fl = (roll_x - yaw_x) <<< 1;
   assign exp_rr_rl = (roll_x + yaw_x) <<< 1;
   assign exp_rr_fr = (pitch_x + yaw_x) <<< 1;

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled rsp transaction dropped");

   a_mix_roll_yaw: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> fr_fl == exp_fr_fl)
      else $error("front motors disagree with roll and yaw drives");

   a_mix_rear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rr_rl == exp_rr_rl)
      else $error("rear motors disagree with roll and yaw drives");

   a_mix_pitch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rr_fr == exp_rr_fr)
      else $error("right motors disagree with pitch and yaw drives");

endmodule

bind quad_attitude_pid_mixer qapm_checker u_qapm_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_roll_drive        (rsp_roll_drive),
   .rsp_pitch_drive       (rsp_pitch_drive),
   .rsp_yaw_drive         (rsp_yaw_drive),
   .rsp_motor_front_right (rsp_motor_front_right),
   .rsp_motor_front_left  (rsp_motor_front_left),
   .rsp_motor_rear_left   (rsp_motor_rear_left),
   .rsp_motor_rear_right  (rsp_motor_rear_right)
);

`default_nettype wire

// ===== verif/quad_attitude_pid_mixer_tb.sv =====
// quad_attitude_pid_mixer_tb: self-checking testbench for the quad attitude PID mixer.
// A scoreboard class predicts every response. Directed ticks and randomized gain
// settings are driven through valid/stall handshakes. Depends on qapm_pkg and the RTL.
module quad_attitude_pid_mixer_tb
   import qapm_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SW       = 16;
   localparam int INT_FRAC = 12;
   localparam int SUM_FRAC = (INT_FRAC > PROD_FRAC) ? INT_FRAC : PROD_FRAC;

   localparam logic signed [SW-1:0] ANGLE_MIN = {1'b1, {(SW-1){1'b0}}};
   localparam logic signed [SW-1:0] ANGLE_MAX = {1'b0, {(SW-1){1'b1}}};
   localparam logic [THROTTLE_WIDTH-1:0] THR_MAX = '1;
   localparam logic [CSR_DATA_WIDTH-1:0] ALL_ONES = '1;

   typedef struct {
      logic signed [SW-1:0]        roll;
      logic signed [SW-1:0]        pitch;
      logic signed [SW-1:0]        yaw;
      logic [THROTTLE_WIDTH-1:0]   throttle;
   } tick_type;

   typedef struct {
      logic signed [DRIVE_WIDTH-1:0] roll;
      logic signed [DRIVE_WIDTH-1:0] pitch;
      logic signed [DRIVE_WIDTH-1:0] yaw;
      logic signed [MOTOR_WIDTH-1:0] fr;
      logic signed [MOTOR_WIDTH-1:0] fl;
      logic signed [MOTOR_WIDTH-1:0] rl;
      logic signed [MOTOR_WIDTH-1:0] rr;
   } motor_cmd_type;

   class attitude_scoreboard;
      logic [CSR_DATA_WIDTH-1:0] regs [8];
      longint integ [3];
      longint prev_err [3];
      motor_cmd_type expected [$];
      int mismatches;
      int ticks_checked;

      function new();
         regs[CSR_RP_P_GAIN]  = RP_P_GAIN_RESET;
         regs[CSR_RP_I_GAIN]  = RP_I_GAIN_RESET;
         regs[CSR_RP_D_GAIN]  = RP_D_GAIN_RESET;
         regs[CSR_RP_LIMIT]   = RP_LIMIT_RESET;
         regs[CSR_YAW_P_GAIN] = YAW_P_GAIN_RESET;
         regs[CSR_YAW_I_GAIN] = YAW_I_GAIN_RESET;
         regs[CSR_YAW_D_GAIN] = YAW_D_GAIN_RESET;
         regs[CSR_YAW_LIMIT]  = YAW_LIMIT_RESET;
         for (int i = 0; i < 3; i++) begin
            integ[i]    = 0;
            prev_err[i] = 0;
         end
         mismatches    = 0;
         ticks_checked = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_WIDTH-1:0] value);
         if (idx == CSR_RP_LIMIT || idx == CSR_YAW_LIMIT)
            regs[idx] = CSR_DATA_WIDTH'(value[LIMIT_WIDTH-1:0]);
         else
            regs[idx] = value;
      endfunction

      function longint clamp(longint x, longint lim);
         if (x > lim) return lim;
         if (x < -lim) return -lim;
         return x;
      endfunction

      // one PID axis; returns the drive truncated toward zero
      function longint axis_drive(int ax, logic signed [SW-1:0] raw, bit yaw_axis);
         longint err, pg, ig, dg, lim, inc, sum;
         pg  = longint'(yaw_axis ? regs[CSR_YAW_P_GAIN] : regs[CSR_RP_P_GAIN]);
         ig  = longint'(yaw_axis ? regs[CSR_YAW_I_GAIN] : regs[CSR_RP_I_GAIN]);
         dg  = longint'(yaw_axis ? regs[CSR_YAW_D_GAIN] : regs[CSR_RP_D_GAIN]);
         lim = longint'(yaw_axis ? regs[CSR_YAW_LIMIT] : regs[CSR_RP_LIMIT]);
         err = -longint'(raw);
         inc = ig * err;
         if (INT_FRAC >= PROD_FRAC)
            inc = inc <<< (INT_FRAC - PROD_FRAC);
         else
            inc = inc >>> (PROD_FRAC - INT_FRAC);
         integ[ax] = clamp(integ[ax] + inc, lim <<< INT_FRAC);
         sum = ((pg * err) <<< (SUM_FRAC - PROD_FRAC))
             + (integ[ax] <<< (SUM_FRAC - INT_FRAC))
             + ((dg * (err - prev_err[ax])) <<< (SUM_FRAC - PROD_FRAC));
         sum = clamp(sum, lim <<< SUM_FRAC);
         prev_err[ax] = err;
         if (sum < 0) return -((-sum) >>> SUM_FRAC);
         return sum >>> SUM_FRAC;
      endfunction

      function void note_tick(tick_type t);
         longint r, p, y, thr;
         motor_cmd_type m;
         r   = axis_drive(0, t.roll, 1'b0);
         p   = axis_drive(1, t.pitch, 1'b0);
         y   = axis_drive(2, t.yaw, 1'b1);
         thr = longint'(t.throttle);
         m.roll  = DRIVE_WIDTH'(r);
         m.pitch = DRIVE_WIDTH'(p);
         m.yaw   = DRIVE_WIDTH'(y);
         m.fr    = MOTOR_WIDTH'(thr - p + r - y);
         m.fl    = MOTOR_WIDTH'(thr - p - r + y);
         m.rl    = MOTOR_WIDTH'(thr + p - r - y);
         m.rr    = MOTOR_WIDTH'(thr + p + r + y);
         expected.push_back(m);
      endfunction

      task report(string field, longint got_v, longint want_v);
         $display("[%0t] response %0d %s: got %0d expected %0d",
                  $time, ticks_checked, field, got_v, want_v);
         mismatches++;
      endtask

      task check(motor_cmd_type got);
         motor_cmd_type want;
         if (expected.size() == 0) begin
            report("unexpected transaction", 0, 0);
            return;
         end
         want = expected.pop_front();
         ticks_checked++;
         if (got.roll !== want.roll) report("roll_drive", got.roll, want.roll);
         if (got.pitch !== want.pitch) report("pitch_drive", got.pitch, want.pitch);
         if (got.yaw !== want.yaw) report("yaw_drive", got.yaw, want.yaw);
         if (got.fr !== want.fr) report("motor_front_right", got.fr, want.fr);
         if (got.fl !== want.fl) report("motor_front_left", got.fl, want.fl);
         if (got.rl !== want.rl) report("motor_rear_left", got.rl, want.rl);
         if (got.rr !== want.rr) report("motor_rear_right", got.rr, want.rr);
      endtask
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [SW-1:0] req_roll_angle;
   logic signed [SW-1:0] req_pitch_angle;
   logic signed [SW-1:0] req_yaw_measure;
   logic [THROTTLE_WIDTH-1:0] req_throttle_level;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [DRIVE_WIDTH-1:0] rsp_roll_drive;
   logic signed [DRIVE_WIDTH-1:0] rsp_pitch_drive;
   logic signed [DRIVE_WIDTH-1:0] rsp_yaw_drive;
   logic signed [MOTOR_WIDTH-1:0] rsp_motor_front_right;
   logic signed [MOTOR_WIDTH-1:0] rsp_motor_front_left;
   logic signed [MOTOR_WIDTH-1:0] rsp_motor_rear_left;
   logic signed [MOTOR_WIDTH-1:0] rsp_motor_rear_right;
   logic csr_write;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0] csr_data;

   attitude_scoreboard sb;
   bit sender_idles;
   bit receiver_idles;
   int rsp_hold;

   quad_attitude_pid_mixer DUT (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // response side: random stall after each accepted transaction while receiver_idles is set
   always @(posedge clock) begin
      motor_cmd_type got;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.roll  = rsp_roll_drive;
            got.pitch = rsp_pitch_drive;
            got.yaw   = rsp_yaw_drive;
            got.fr    = rsp_motor_front_right;
            got.fl    = rsp_motor_front_left;
            got.rl    = rsp_motor_rear_left;
            got.rr    = rsp_motor_rear_right;
            sb.check(got);
            rsp_hold = receiver_idles ? $urandom_range(0, 18) : 0;
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_stall <= (rsp_hold > 0);
      end
   end

   function automatic tick_type mk_tick(logic signed [SW-1:0] r, logic signed [SW-1:0] p,
                                        logic signed [SW-1:0] y,
                                        logic [THROTTLE_WIDTH-1:0] thr);
      tick_type t;
      t.roll     = r;
      t.pitch    = p;
      t.yaw      = y;
      t.throttle = thr;
      return t;
   endfunction

   function automatic logic signed [SW-1:0] pick_angle(logic signed [SW-1:0] last);
      case ($urandom_range(0, 7))
         0, 1:    return SW'($urandom);
         2, 3, 4: return SW'(int'($urandom_range(0, 1600)) - 800);
         5, 6:    return SW'(int'(last) + int'($urandom_range(0, 80)) - 40);
         default: begin
            case ($urandom_range(0, 3))
               0:       return ANGLE_MIN;
               1:       return ANGLE_MAX;
               2:       return '0;
               default: return '1;
            endcase
         end
      endcase
   endfunction

   function automatic logic [THROTTLE_WIDTH-1:0] pick_throttle();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return THR_MAX;
         default: return THROTTLE_WIDTH'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_DATA_WIDTH-1:0] pick_gain();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return ALL_ONES;
         2:       return CSR_DATA_WIDTH'($urandom);
         default: return CSR_DATA_WIDTH'($urandom_range(0, 1024));
      endcase
   endfunction

   // upper bits are random; the register keeps only the low ten
   function automatic logic [CSR_DATA_WIDTH-1:0] pick_limit();
      logic [LIMIT_WIDTH-1:0] lim;
      case ($urandom_range(0, 5))
         0:       lim = '0;
         1:       lim = '1;
         default: lim = LIMIT_WIDTH'($urandom_range(1, 1023));
      endcase
      return {6'($urandom), lim};
   endfunction

   task automatic send_tick(input tick_type t);
      int gap;
      gap = sender_idles ? $urandom_range(0, 18) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_roll_angle     <= t.roll;
      req_pitch_angle    <= t.pitch;
      req_yaw_measure    <= t.yaw;
      req_throttle_level <= t.throttle;
      do @(posedge clock); while (req_stall);
      sb.note_tick(t);
   endtask

   // hold off until every expected response is back, then let the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.expected.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_WIDTH-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   task automatic set_gains(input logic [CSR_DATA_WIDTH-1:0] rp_p, rp_i, rp_d, rp_lim,
                            input logic [CSR_DATA_WIDTH-1:0] y_p, y_i, y_d, y_lim);
      write_reg(CSR_RP_P_GAIN, rp_p);
      write_reg(CSR_RP_I_GAIN, rp_i);
      write_reg(CSR_RP_D_GAIN, rp_d);
      write_reg(CSR_RP_LIMIT, rp_lim);
      write_reg(CSR_YAW_P_GAIN, y_p);
      write_reg(CSR_YAW_I_GAIN, y_i);
      write_reg(CSR_YAW_D_GAIN, y_d);
      write_reg(CSR_YAW_LIMIT, y_lim);
      csr_write <= 1'b0;
   endtask

   initial begin
      logic signed [SW-1:0] last_r, last_p, last_y;
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_roll_angle     <= '0;
      req_pitch_angle    <= '0;
      req_yaw_measure    <= '0;
      req_throttle_level <= '0;
      csr_write          <= 1'b0;
      csr_index          <= CSR_RP_P_GAIN;
      csr_data           <= '0;
      sb             = new();
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // default gains, full-scale and most negative samples
      send_tick(mk_tick(0, 0, 0, 0));
      send_tick(mk_tick(ANGLE_MIN, ANGLE_MIN, ANGLE_MIN, 0));
      send_tick(mk_tick(ANGLE_MAX, ANGLE_MAX, ANGLE_MAX, THR_MAX));
      send_tick(mk_tick(ANGLE_MIN, ANGLE_MAX, ANGLE_MIN, THR_MAX));
      send_tick(mk_tick(ANGLE_MAX, ANGLE_MIN, ANGLE_MAX, 2048));
      send_tick(mk_tick(-1, 1, -1, 1));
      send_tick(mk_tick(16, -16, 160, 1000));
      send_tick(mk_tick(0, 0, 0, THR_MAX));
      send_tick(mk_tick(-160, 320, -3200, 1500));
      send_tick(mk_tick(ANGLE_MIN, ANGLE_MIN, ANGLE_MIN, THR_MAX));

      // zero limit forces integrator and drive to zero
      settle();
      set_gains(1000, 200, 3000, 0, 900, 300, 2000, 0);
      send_tick(mk_tick(ANGLE_MAX, ANGLE_MIN, ANGLE_MIN, THR_MAX));
      send_tick(mk_tick(ANGLE_MIN, ANGLE_MAX, ANGLE_MAX, 0));
      send_tick(mk_tick(100, -100, 50, 2000));

      // maximum gains, limit writes carry high bits that must be dropped
      settle();
      set_gains(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
      send_tick(mk_tick(ANGLE_MIN, ANGLE_MIN, ANGLE_MIN, THR_MAX));
      send_tick(mk_tick(ANGLE_MAX, ANGLE_MAX, ANGLE_MAX, 0));
      send_tick(mk_tick(ANGLE_MIN, ANGLE_MAX, 0, THR_MAX));
      send_tick(mk_tick(0, 0, 0, 0));
      send_tick(mk_tick(ANGLE_MAX, ANGLE_MIN, ANGLE_MAX, 0));

      // zero gains
      settle();
      set_gains(0, 0, 0, 1023, 0, 0, 0, 1023);
      send_tick(mk_tick(ANGLE_MAX, ANGLE_MIN, ANGLE_MAX, 100));
      send_tick(mk_tick(1, -1, 1, 0));

      last_r = '0;
      last_p = '0;
      last_y = '0;
      for (int phase = 0; phase < 10; phase++) begin
         settle();
         if (phase == 0)
            set_gains(RP_P_GAIN_RESET, RP_I_GAIN_RESET, RP_D_GAIN_RESET,
                      CSR_DATA_WIDTH'(RP_LIMIT_RESET),
                      YAW_P_GAIN_RESET, YAW_I_GAIN_RESET, YAW_D_GAIN_RESET,
                      CSR_DATA_WIDTH'(YAW_LIMIT_RESET));
         else
            set_gains(pick_gain(), pick_gain(), pick_gain(), pick_limit(),
                      pick_gain(), pick_gain(), pick_gain(), pick_limit());
         sender_idles   = (phase == 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
         receiver_idles = (phase == 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
         for (int n = 0; n < 110; n++) begin
            last_r = pick_angle(last_r);
            last_p = pick_angle(last_p);
            last_y = pick_angle(last_y);
            send_tick(mk_tick(last_r, last_p, last_y, pick_throttle()));
            if ($urandom_range(0, 199) == 0)
               settle();
         end
      end

      settle();
      if (sb.mismatches == 0 && sb.expected.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
